// ----- hw/rtl/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and types for the frame receiver: receive phases,
// result kinds, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package pfr_pkg;

  // receive phases
  localparam logic [2:0] PH_SYNC  = 3'd0;
  localparam logic [2:0] PH_DEST  = 3'd1;
  localparam logic [2:0] PH_SRC   = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_LENHI = 3'd4;
  localparam logic [2:0] PH_LENLO = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;

  // result kinds
  localparam logic [2:0] K_PAYLOAD = 3'd0;
  localparam logic [2:0] K_EMPTY   = 3'd1;
  localparam logic [2:0] K_BADSYNC = 3'd2;
  localparam logic [2:0] K_BADDEST = 3'd3;
  localparam logic [2:0] K_BADSRC  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE = 2'd2;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [15:0] index;
    logic [7:0]  data;
    logic        last;
  } result_t;

endpackage

// ----- hw/rtl/phonet_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// phonet_frame_receiver_core
// Byte-serial frame receiver: checks sync, destination and source bytes,
// captures type and big-endian length, and reports each payload byte, each empty frame and each failed check.
// ----------------------------------------------------------------------------
// One received byte is accepted per cycle, every cycle, as long as the
// two-entry result buffer (output register plus skid register) has room;
// the result of a byte, when it has one, goes into the output register, or
// into the skid register while the output is stalled. The frame phase
// advances by one step per byte in a single combinational pass. Configuration
// writes are always ready and a write to an index above 2 is dropped.
module phonet_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [pfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data,
  // received byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  frame_type_out,
  output logic [15:0] frame_length_out,
  output logic [15:0] payload_index,
  output logic [7:0]  payload_byte,
  output logic        last
);

  // configuration registers
  logic [7:0] sync_byte;
  logic [7:0] dest_byte;
  logic [7:0] source_byte;

  // frame state
  logic [2:0]  rx_phase;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;
  logic [15:0] byte_count;
  logic [2:0]  rx_phase_next;
  logic [7:0]  frame_type_next;
  logic [15:0] frame_length_next;
  logic [15:0] byte_count_next;

  // result path
  pfr_pkg::result_t res;
  logic             res_push;
  pfr_pkg::result_t out_reg;
  pfr_pkg::result_t skid;
  logic             skid_valid;

  logic        in_fire;
  logic        out_free;
  logic [15:0] count_inc;
  logic [15:0] len_low;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte   <= 8'd0;
      dest_byte   <= 8'd0;
      source_byte <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfr_pkg::REG_SYNC:   sync_byte   <= cfg_data;
        pfr_pkg::REG_DEST:   dest_byte   <= cfg_data;
        pfr_pkg::REG_SOURCE: source_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // one phase step per byte
  assign count_inc = byte_count + 16'd1;
  assign len_low   = {frame_length[15:8], rx_byte};

  always_comb begin
    rx_phase_next     = rx_phase;
    frame_type_next   = frame_type;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    res_push          = 1'b0;
    res               = '0;
    res.data          = rx_byte;
    case (rx_phase)
      pfr_pkg::PH_DEST: begin
        if (rx_byte != dest_byte) begin
          rx_phase_next = pfr_pkg::PH_SYNC;
          res.kind      = pfr_pkg::K_BADDEST;
          res_push      = 1'b1;
        end else begin
          rx_phase_next = pfr_pkg::PH_SRC;
        end
      end
      pfr_pkg::PH_SRC: begin
        if (rx_byte != source_byte) begin
          rx_phase_next = pfr_pkg::PH_SYNC;
          res.kind      = pfr_pkg::K_BADSRC;
          res_push      = 1'b1;
        end else begin
          rx_phase_next = pfr_pkg::PH_TYPE;
        end
      end
      pfr_pkg::PH_TYPE: begin
        frame_type_next = rx_byte;
        rx_phase_next   = pfr_pkg::PH_LENHI;
      end
      pfr_pkg::PH_LENHI: begin
        frame_length_next = {rx_byte, 8'h00};
        rx_phase_next     = pfr_pkg::PH_LENLO;
      end
      pfr_pkg::PH_LENLO: begin
        frame_length_next = len_low;
        if (len_low == 16'd0) begin
          rx_phase_next  = pfr_pkg::PH_SYNC;
          res.kind       = pfr_pkg::K_EMPTY;
          res.frame_type = frame_type;
          res.data       = 8'd0;
          res.last       = 1'b1;
          res_push       = 1'b1;
        end else begin
          rx_phase_next = pfr_pkg::PH_DATA;
        end
      end
      pfr_pkg::PH_DATA: begin
        byte_count_next  = count_inc;
        res.kind         = pfr_pkg::K_PAYLOAD;
        res.frame_type   = frame_type;
        res.frame_length = frame_length;
        res.index        = byte_count;
        res.last         = (count_inc == frame_length) || (byte_count >= frame_length);
        res_push         = 1'b1;
        if (res.last) begin
          rx_phase_next = pfr_pkg::PH_SYNC;
        end
      end
      default: begin
        // waiting for sync, also the unused phase code
        if (rx_byte == sync_byte) begin
          byte_count_next = 16'd0;
          rx_phase_next   = pfr_pkg::PH_DEST;
        end else begin
          rx_phase_next = pfr_pkg::PH_SYNC;
          res.kind      = pfr_pkg::K_BADSYNC;
          res_push      = 1'b1;
        end
      end
    endcase
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase     <= pfr_pkg::PH_SYNC;
      frame_type   <= 8'd0;
      frame_length <= 16'd0;
      byte_count   <= 16'd0;
    end else if (in_fire) begin
      rx_phase     <= rx_phase_next;
      frame_type   <= frame_type_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire && res_push;
      end
    end else if (in_fire && res_push) begin
      skid_valid <= 1'b1;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (in_fire && res_push) begin
        out_reg <= res;
      end
    end else if (in_fire && res_push) begin
      skid <= res;
    end
  end

  assign result_kind      = out_reg.kind;
  assign frame_type_out   = out_reg.frame_type;
  assign frame_length_out = out_reg.frame_length;
  assign payload_index    = out_reg.index;
  assign payload_byte     = out_reg.data;
  assign last             = out_reg.last;

endmodule
